[src/rgb_to_xterm256_index_top_defines.svh]
`ifndef RGB_TO_XTERM256_INDEX_TOP_DEFINES_SVH
`define RGB_TO_XTERM256_INDEX_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define XTI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("xti assertion failed");

// next-cycle implication, checked outside reset
`define XTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("xti assertion failed");

`endif

[src/xti_pkg.sv]
package xti_pkg;

  typedef logic [7:0]  pix_t;
  typedef logic [2:0]  lvl_t;
  typedef logic [15:0] sq_t;
  typedef logic [17:0] dist_t;
  typedef logic [9:0]  sum_t;

  localparam pix_t CubeBase  = 8'd16;
  localparam pix_t CubeTop   = 8'd231;
  localparam pix_t RampBase  = 8'd232;
  localparam pix_t GreyLow   = 8'd8;
  localparam pix_t GreyHigh  = 8'd248;
  localparam pix_t RampFirst = 8'd8;
  localparam pix_t RampStep  = 8'd10;
  localparam pix_t CubeRedW  = 8'd36;
  localparam pix_t CubeGrnW  = 8'd6;

  // (v - 8) * 24 / 241 as a multiply by 104424, just above 24 * 2^20 / 241
  localparam logic [16:0] RampRecip = 17'd104424;
  localparam int unsigned RampShift = 20;
  // sum / 3 for sums up to 765
  localparam sum_t        ThirdRecip = 10'd683;
  localparam int unsigned ThirdShift = 11;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    lvl_t red_lvl;
    lvl_t green_lvl;
    lvl_t blue_lvl;
    sum_t sum;
    logic is_grey;
    pix_t grey_idx;
  } quant_t;

  typedef struct packed {
    dist_t cube_sq_sum;
    sq_t   ramp_sq_r;
    sq_t   ramp_sq_g;
    sq_t   ramp_sq_b;
    pix_t  ramp_idx;
    pix_t  cube_idx;
    logic  is_grey;
    pix_t  grey_idx;
  } cand_t;

  function automatic lvl_t cube_step(input pix_t c);
    lvl_t lv;
    priority if (c == 8'd0) lv = 3'd0;
    else if (c < 8'd75)     lv = 3'd1;
    else if (c < 8'd115)    lv = 3'd2;
    else if (c < 8'd155)    lv = 3'd3;
    else if (c < 8'd195)    lv = 3'd4;
    else                    lv = 3'd5;
    return lv;
  endfunction

  function automatic pix_t cube_value(input lvl_t lv);
    pix_t v;
    unique case (lv)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd95;
      3'd2:    v = 8'd135;
      3'd3:    v = 8'd175;
      3'd4:    v = 8'd215;
      default: v = 8'd255;
    endcase
    return v;
  endfunction

  function automatic pix_t abs_diff(input pix_t a, input pix_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

[src/xti_quant.sv]
module xti_quant (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [7:0]     red_i,
  input  logic [7:0]     green_i,
  input  logic [7:0]     blue_i,
  output xti_pkg::quant_t quant_o
);
  import xti_pkg::*;

  quant_t      quant_d, quant_q;
  pix_t        grey_off;
  logic [24:0] ramp_prod;

  assign grey_off  = red_i - GreyLow;
  assign ramp_prod = grey_off * RampRecip;

  always_comb begin
    quant_d.red       = red_i;
    quant_d.green     = green_i;
    quant_d.blue      = blue_i;
    quant_d.red_lvl   = cube_step(red_i);
    quant_d.green_lvl = cube_step(green_i);
    quant_d.blue_lvl  = cube_step(blue_i);
    quant_d.sum       = sum_t'(red_i) + sum_t'(green_i) + sum_t'(blue_i);
    quant_d.is_grey   = (red_i == green_i) && (green_i == blue_i);
    priority if (red_i < GreyLow) begin
      quant_d.grey_idx = CubeBase;
    end else if (red_i > GreyHigh) begin
      quant_d.grey_idx = CubeTop;
    end else begin
      quant_d.grey_idx = RampBase + pix_t'(ramp_prod[RampShift +: 5]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quant_q <= quant_d;
    end
  end

  assign quant_o = quant_q;

endmodule

[src/xti_dist.sv]
module xti_dist (
  input  logic            clk_i,
  input  logic [2:0]      en_i,
  input  xti_pkg::quant_t quant_i,
  output xti_pkg::cand_t  cand_o
);
  import xti_pkg::*;

  typedef struct packed {
    pix_t diff_r;
    pix_t diff_g;
    pix_t diff_b;
    pix_t avg;
    pix_t cube_idx;
    pix_t red;
    pix_t green;
    pix_t blue;
    logic is_grey;
    pix_t grey_idx;
  } diff_t;

  typedef struct packed {
    sq_t  sq_r;
    sq_t  sq_g;
    sq_t  sq_b;
    pix_t ramp_idx;
    pix_t ramp_lvl;
    pix_t red;
    pix_t green;
    pix_t blue;
    pix_t cube_idx;
    logic is_grey;
    pix_t grey_idx;
  } sq_stage_t;

  diff_t       diff_d, diff_q;
  sq_stage_t   sq_d, sq_q;
  cand_t       cand_d, cand_q;
  logic [19:0] third_prod;
  sum_t        avg3;
  logic [4:0]  ramp_off;
  pix_t        gdr, gdg, gdb;

  // cube distance per channel, and the channel mean
  assign third_prod = quant_i.sum * ThirdRecip;

  always_comb begin
    diff_d.diff_r   = abs_diff(cube_value(quant_i.red_lvl), quant_i.red);
    diff_d.diff_g   = abs_diff(cube_value(quant_i.green_lvl), quant_i.green);
    diff_d.diff_b   = abs_diff(cube_value(quant_i.blue_lvl), quant_i.blue);
    diff_d.avg      = third_prod[ThirdShift +: 8];
    diff_d.cube_idx = CubeBase + pix_t'(quant_i.red_lvl) * CubeRedW
                      + pix_t'(quant_i.green_lvl) * CubeGrnW + pix_t'(quant_i.blue_lvl);
    diff_d.red      = quant_i.red;
    diff_d.green    = quant_i.green;
    diff_d.blue     = quant_i.blue;
    diff_d.is_grey  = quant_i.is_grey;
    diff_d.grey_idx = quant_i.grey_idx;
  end

  // avg * 24 / 256 is avg * 3 / 32
  assign avg3     = sum_t'(diff_q.avg) + {1'b0, diff_q.avg, 1'b0};
  assign ramp_off = avg3[9:5];

  always_comb begin
    sq_d.sq_r     = diff_q.diff_r * diff_q.diff_r;
    sq_d.sq_g     = diff_q.diff_g * diff_q.diff_g;
    sq_d.sq_b     = diff_q.diff_b * diff_q.diff_b;
    sq_d.ramp_idx = RampBase + pix_t'(ramp_off);
    sq_d.ramp_lvl = RampFirst + pix_t'(ramp_off) * RampStep;
    sq_d.red      = diff_q.red;
    sq_d.green    = diff_q.green;
    sq_d.blue     = diff_q.blue;
    sq_d.cube_idx = diff_q.cube_idx;
    sq_d.is_grey  = diff_q.is_grey;
    sq_d.grey_idx = diff_q.grey_idx;
  end

  assign gdr = abs_diff(sq_q.ramp_lvl, sq_q.red);
  assign gdg = abs_diff(sq_q.ramp_lvl, sq_q.green);
  assign gdb = abs_diff(sq_q.ramp_lvl, sq_q.blue);

  always_comb begin
    cand_d.cube_sq_sum = dist_t'(sq_q.sq_r) + dist_t'(sq_q.sq_g) + dist_t'(sq_q.sq_b);
    cand_d.ramp_sq_r   = gdr * gdr;
    cand_d.ramp_sq_g   = gdg * gdg;
    cand_d.ramp_sq_b   = gdb * gdb;
    cand_d.ramp_idx    = sq_q.ramp_idx;
    cand_d.cube_idx    = sq_q.cube_idx;
    cand_d.is_grey     = sq_q.is_grey;
    cand_d.grey_idx    = sq_q.grey_idx;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      diff_q <= diff_d;
    end
    if (en_i[1]) begin
      sq_q <= sq_d;
    end
    if (en_i[2]) begin
      cand_q <= cand_d;
    end
  end

  assign cand_o = cand_q;

endmodule

[src/xti_select.sv]
module xti_select (
  input  logic           clk_i,
  input  logic           en_i,
  input  xti_pkg::cand_t cand_i,
  output logic [7:0]     palette_index_o
);
  import xti_pkg::*;

  dist_t ramp_dist;
  pix_t  index_d, index_q;

  assign ramp_dist = dist_t'(cand_i.ramp_sq_r) + dist_t'(cand_i.ramp_sq_g)
                     + dist_t'(cand_i.ramp_sq_b);

  // the ramp entry must be strictly closer to beat the cube
  always_comb begin
    priority if (cand_i.is_grey) begin
      index_d = cand_i.grey_idx;
    end else if (ramp_dist < cand_i.cube_sq_sum) begin
      index_d = cand_i.ramp_idx;
    end else begin
      index_d = cand_i.cube_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      index_q <= index_d;
    end
  end

  assign palette_index_o = index_q;

endmodule

[src/rgb_to_xterm256_index_top.sv]
// rgb to xterm 256-color index converter
// input channel: valid_i with red_i, green_i, blue_i; stall_o pushes back.
// output channel: valid_o with palette_index_o; stall_i from the receiver.
// an item moves on a channel at a clock edge where valid is high and stall low.
// five register stages: channel levels and grey path, cube distances and mean,
// squares and ramp entry, ramp distances, final pick into the output register.
// valid_o rises once an accepted item has passed all five stages; one item per cycle
// is sustained while stall_i stays low.
// each stage holds its item when the next one is full and cannot move, so
// bubbles close up and input is still taken while a result waits at the output.
// stall_o rises only when all five stages hold items and stall_i is high.
// stalled results stay unchanged on palette_index_o until taken.
// reset (rst_ni low, asynchronous) empties the pipeline; data registers are not reset.
module rgb_to_xterm256_index_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] palette_index_o
);
  import xti_pkg::*;

  `include "rgb_to_xterm256_index_top_defines.svh"

  logic [4:0] valid_d, valid_q;
  logic [4:0] en;
  quant_t     quant;
  cand_t      cand;

  // a stage loads when empty or when its successor loads
  always_comb begin
    en[4] = !valid_q[4] || !stall_i;
    for (int k = 3; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d[0] = en[0] ? valid_i : valid_q[0];
    for (int k = 1; k < 5; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stall_o = !en[0];
  assign valid_o = valid_q[4];

  xti_quant u_quant (
    .clk_i   (clk_i),
    .en_i    (en[0]),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .quant_o (quant)
  );

  xti_dist u_dist (
    .clk_i   (clk_i),
    .en_i    (en[3:1]),
    .quant_i (quant),
    .cand_o  (cand)
  );

  xti_select u_select (
    .clk_i           (clk_i),
    .en_i            (en[4]),
    .cand_i          (cand),
    .palette_index_o (palette_index_o)
  );

  `XTI_ASSERT_NOW(a_full_stall, clk_i, rst_ni, (&valid_q) && stall_i, stall_o)
  `XTI_ASSERT_NOW(a_empty_ready, clk_i, rst_ni, !valid_q[0], !stall_o)
  `XTI_ASSERT_NEXT(a_accept_loads, clk_i, rst_ni, valid_i && !stall_o, valid_q[0])
  `XTI_ASSERT_NOW(a_index_range, clk_i, rst_ni, valid_o, palette_index_o >= CubeBase)

endmodule
